// ===== design/mwf_pkg.sv =====
`timescale 1ns / 1ps
package mwf_pkg;
    localparam int MaxWindowDef = 15;
    localparam int MaxWidthDef  = 1024;
    localparam int HeightLimit  = 1024;
    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [4:0]  k;
        logic [12:0] w;
        logic [10:0] hgt;
    } t_geom;
endpackage

// ===== design/mwf_line_mem.sv =====
`timescale 1ns / 1ps
module mwf_line_mem #(
    parameter int AW = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [0:(1<<AW)-1];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/mwf_hist_mem.sv =====
`timescale 1ns / 1ps
module mwf_hist_mem (
    input  logic       i_clk,
    input  logic       i_we,
    input  logic [7:0] i_waddr,
    input  logic [8:0] i_wdata,
    input  logic [7:0] i_raddr,
    output logic [8:0] o_rdata
);
    logic [8:0] r_mem [0:255];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/median_window_filter.sv =====
`timescale 1ns / 1ps
// After the input transaction that completes its window, the filter reads each window tap and
// counts it in a histogram, searches the bins in order for the median, then presents it.
// No new input is taken while a window is processed, while a result waits to be taken or
// while the histogram bins are cleared after each result.
// Reset: i_rst_n synchronous, active low; sets configuration defaults, clears counters, then
// clears all histogram bins before the first input is taken. Line memory is not cleared.
module median_window_filter
    import mwf_pkg::*;
#(
    parameter int MAX_WINDOW = MaxWindowDef,
    parameter int MAX_WIDTH  = MaxWidthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  logic        s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] median_value
    output logic        m_axis_tlast    // last_pixel
);
    localparam int RowsStore = 1 << $clog2(MAX_WINDOW + 1);
    localparam int RowBits   = $clog2(RowsStore);
    localparam int ColBits   = $clog2(MAX_WIDTH);
    localparam int AW        = RowBits + ColBits;
    localparam int KMax      = ((MAX_WINDOW % 2) == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_SRCH = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_SCLR = 3'd6;

    // Configuration registers and derived geometry
    logic [3:0]  r_win;
    logic [10:0] r_wid, r_hgt;
    t_geom       g;
    logic [4:0]  k_raw;

    always_comb begin
        k_raw = {1'b0, r_win};
        if (k_raw == 5'd0) k_raw = 5'd1;
        if (!k_raw[0]) k_raw = k_raw - 5'd1;
        if (k_raw > 5'(KMax)) k_raw = 5'(KMax);
        g.k = k_raw;
        g.w = (r_wid == 11'd0) ? 13'd1 :
              ({2'b0, r_wid} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {2'b0, r_wid};
        g.hgt = (r_hgt == 11'd0) ? 11'd1 :
                (r_hgt > 11'(HeightLimit)) ? 11'(HeightLimit) : r_hgt;
    end

    logic [4:0] h;
    assign h = g.k >> 1;

    // Frame counters
    logic [12:0] r_col, r_row;
    logic [12:0] r_ocol, r_orow;   // output position
    logic [2:0]  r_state;
    // tap walk
    logic [4:0]  r_dr, r_dc;
    logic [8:0]  r_cnt;
    logic        r_tap_zero;
    logic        r_tap_ph;
    logic [7:0]  r_bin;
    logic [9:0]  r_acc;
    logic [8:0]  r_target;
    logic [7:0]  r_med;
    logic        r_last;
    logic        r_ovalid;

    // line memory
    logic          lm_we;
    logic [AW-1:0] lm_waddr, lm_raddr;
    logic [7:0]    lm_wdata, lm_rdata;
    mwf_line_mem #(.AW(AW)) u_line (
        .i_clk(i_clk), .i_we(lm_we), .i_waddr(lm_waddr), .i_wdata(lm_wdata),
        .i_raddr(lm_raddr), .o_rdata(lm_rdata)
    );

    // histogram memory
    logic       hm_we;
    logic [7:0] hm_waddr, hm_raddr;
    logic [8:0] hm_wdata, hm_rdata;
    mwf_hist_mem u_hist (
        .i_clk(i_clk), .i_we(hm_we), .i_waddr(hm_waddr), .i_wdata(hm_wdata),
        .i_raddr(hm_raddr), .o_rdata(hm_rdata)
    );

    // Tap coordinates (signed offsets around output position)
    logic signed [14:0] tr, tc;
    logic               tap_out;
    logic [RowBits-1:0] tap_row_mod;
    always_comb begin
        tr = $signed({2'b0, r_orow}) + $signed({10'b0, r_dr}) - $signed({10'b0, h});
        tc = $signed({2'b0, r_ocol}) + $signed({10'b0, r_dc}) - $signed({10'b0, h});
        tap_out = (tr < 0) || (tr >= $signed({4'b0, g.hgt})) ||
                  (tc < 0) || (tc >= $signed({2'b0, g.w}));
        tap_row_mod = RowBits'(tr[12:0] % 13'(RowsStore));
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid && !i_cfg_we;
    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Raster index of input and latency compare
    logic [22:0] n_in, lat;
    assign n_in = 23'(r_row) * 23'(g.w) + 23'(r_col);
    assign lat  = 23'(h) * 23'(g.w) + 23'(h);

    logic hist_hit;
    assign hist_hit = (r_acc + 10'(hm_rdata)) > {1'b0, r_target};

    always_comb begin
        lm_we    = in_acc && !i_cfg_we;
        lm_waddr = {RowBits'(r_row % 13'(RowsStore)), r_col[ColBits-1:0]};
        lm_wdata = (s_axis_tuser == OP_PIXEL && r_row < {2'b0, g.hgt}) ? s_axis_tdata : 8'd0;
        lm_raddr = {tap_row_mod, tc[ColBits-1:0]};
        hm_we    = 1'b0;
        hm_waddr = r_bin;
        hm_wdata = 9'd0;
        hm_raddr = r_bin;
        case (r_state)
            ST_CLR, ST_SCLR: hm_we = 1'b1;
            ST_UPD: begin
                hm_raddr = r_tap_zero ? 8'd0 : lm_rdata;
            end
            default: ;
        endcase
        if (r_state == ST_UPD && r_tap_ph) begin
            hm_we    = 1'b1;
            hm_waddr = r_bin;
            hm_wdata = hm_rdata + 9'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= 4'd7; r_wid <= 11'd256; r_hgt <= 11'd256;
            r_col <= '0; r_row <= '0; r_ocol <= '0; r_orow <= '0;
            r_state <= ST_CLR; r_bin <= '0; r_ovalid <= 1'b0;
            r_dr <= '0; r_dc <= '0; r_cnt <= '0; r_tap_ph <= 1'b0; r_acc <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                // restart the frame on a write to the window, width or height register
                case (i_cfg_index)
                    CFG_WINDOW: r_win <= i_cfg_data[3:0];
                    CFG_WIDTH:  r_wid <= i_cfg_data;
                    CFG_HEIGHT: r_hgt <= i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index == CFG_WINDOW || i_cfg_index == CFG_WIDTH ||
                    i_cfg_index == CFG_HEIGHT) begin
                    r_col <= '0; r_row <= '0; r_ocol <= '0; r_orow <= '0;
                end
            end
            case (r_state)
                ST_CLR: begin
                    r_bin <= r_bin + 8'd1;
                    if (r_bin == 8'd255) r_state <= ST_IDLE;
                end
                ST_IDLE: if (in_acc && !i_cfg_we) begin
                    if (r_col + 13'd1 >= g.w) begin
                        r_col <= '0; r_row <= r_row + 13'd1;
                    end else r_col <= r_col + 13'd1;
                    if (n_in >= lat) begin
                        r_dr <= '0; r_dc <= '0; r_tap_ph <= 1'b0;
                        r_target <= 9'((10'(g.k) * 10'(g.k)) >> 1);
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    // memory read issued for current tap
                    r_tap_zero <= tap_out;
                    r_tap_ph   <= 1'b0;
                    r_state    <= ST_UPD;
                end
                ST_UPD: begin
                    if (!r_tap_ph) begin
                        r_bin    <= r_tap_zero ? 8'd0 : lm_rdata;
                        r_tap_ph <= 1'b1;
                    end else begin
                        // increment written this cycle; advance tap
                        r_tap_ph <= 1'b0;
                        if (r_dc + 5'd1 >= g.k) begin
                            r_dc <= '0;
                            if (r_dr + 5'd1 >= g.k) begin
                                r_state <= ST_SRCH; r_bin <= 8'd0; r_acc <= '0;
                                r_cnt <= '0;
                            end else begin
                                r_dr <= r_dr + 5'd1; r_state <= ST_RD;
                            end
                        end else begin
                            r_dc <= r_dc + 5'd1; r_state <= ST_RD;
                        end
                    end
                end
                ST_SRCH: begin
                    // cnt[0]=0: address issued; =1: data present
                    r_cnt <= r_cnt + 9'd1;
                    if (r_cnt[0]) begin
                        if (hist_hit || r_bin == 8'd255) begin
                            r_med <= r_bin;
                            r_state <= ST_OUT;
                        end else begin
                            r_acc <= r_acc + 10'(hm_rdata);
                            r_bin <= r_bin + 8'd1;
                        end
                    end
                end
                ST_OUT: begin
                    r_last   <= (23'(r_orow) * 23'(g.w) + 23'(r_ocol) + 23'd1) >=
                                (23'(g.hgt) * 23'(g.w));
                    r_ovalid <= 1'b1;
                    r_bin    <= 8'd0;
                    r_state  <= ST_SCLR;
                end
                ST_SCLR: begin
                    if (r_bin == 8'd0 && r_last) begin
                        r_col <= '0; r_row <= '0; r_ocol <= '0; r_orow <= '0;
                    end else if (r_bin == 8'd0) begin
                        if (r_ocol + 13'd1 >= g.w) begin
                            r_ocol <= '0; r_orow <= r_orow + 13'd1;
                        end else r_ocol <= r_ocol + 13'd1;
                    end
                    r_bin <= r_bin + 8'd1;
                    if (r_bin == 8'd255) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_med;
    assign m_axis_tlast  = r_last;
endmodule
